/* rtl/sorted_list_engine_defines.svh */
// Assertion macros used by the sorted list engine RTL.
`ifndef SORTED_LIST_ENGINE_DEFINES_SVH
`define SORTED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sle_pkg.sv */
package sle_pkg;

	// Default sizing
	localparam int SLE_CAPACITY   = 16;
	localparam int SLE_VALUE_BITS = 32;

	// Fixed field widths of the beats
	localparam int CMD_W    = 3;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH    = 3'd0,
		CMD_POP_MIN = 3'd1,
		CMD_POP_MAX = 3'd2,
		CMD_REMOVE  = 3'd3,
		CMD_SEARCH  = 3'd4
	} sle_cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} sle_status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_CMP,
		FSM_APPLY,
		FSM_REPORT
	} sle_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [DATA_W-1:0] value;
	} sle_req_t;

	typedef struct packed {
		logic [DATA_W-1:0]   min_value;
		logic [DATA_W-1:0]   max_value;
		logic [DATA_W-1:0]   median_value;
		logic [COUNT_W-1:0]  entry_count;
		logic [COUNT_W-1:0]  position;
		logic [STATUS_W-1:0] status;
	} sle_rsp_t;

	// Per-cycle control broadcast to every cell
	typedef struct packed {
		logic cmp;     // latch compare flags against the key
		logic ins;     // insert key after the last entry <= key
		logic del_min; // shift everything one place toward the head
		logic del_at;  // close the gap at the lower-bound entry
	} sle_cell_ctl_t;

endpackage

/* rtl/sle_cell.sv */
module sle_cell import sle_pkg::*; #(
	parameter int INDEX      = 0,
	parameter int CNT_W      = 5,
	parameter int VALUE_BITS = SLE_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sle_cell_ctl_t         ctl,
	input  logic [CNT_W-1:0]      count,
	input  logic [VALUE_BITS-1:0] key,
	input  logic                  left_le,
	input  logic [VALUE_BITS-1:0] left_value,
	input  logic [VALUE_BITS-1:0] right_value,
	output logic [VALUE_BITS-1:0] value,
	output logic                  lt,
	output logic                  le,
	output logic                  eq
);

	logic [VALUE_BITS-1:0] value_q;
	logic [VALUE_BITS-1:0] value_d;
	logic                  lt_q, le_q, eq_q;
	logic                  occ;

	assign occ = CNT_W'(INDEX) < count;

	// Compare flags, only meaningful for occupied cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			le_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp) begin
			lt_q <= occ && (value_q < key);
			le_q <= occ && (value_q <= key);
			eq_q <= occ && (value_q == key);
		end
	end

	// Next value: keep, take key, or take a neighbor
	always_comb begin
		value_d = value_q;
		priority if (ctl.ins) begin
			if (!le_q)
				value_d = left_le ? key : left_value;
		end else if (ctl.del_min) begin
			value_d = right_value;
		end else if (ctl.del_at) begin
			if (!lt_q)
				value_d = right_value;
		end else begin
			value_d = value_q;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;
	assign lt    = lt_q;
	assign le    = le_q;
	assign eq    = eq_q;

endmodule

/* rtl/sorted_list_engine.sv */
// Sorted list engine: a row of CAPACITY cells keeps values in ascending order.
// A request beat is taken when start is high and busy is low; busy then stays
// high through the compare, shift and report states, so a new command is not
// taken until the last one has completed. The result beat appears on result
// with done high for exactly one cycle, after the report state; the receiver
// cannot stall it and must take it at the edge that ends that cycle. A new
// request may be taken at that same edge. The cost per command is set by the
// three-step cell sequence: all cells compare in parallel, then shift in parallel,
// then the min, max and median taps are gathered into the output register.
`include "sorted_list_engine_defines.svh"

module sorted_list_engine import sle_pkg::*; #(
	parameter int CAPACITY   = SLE_CAPACITY,
	parameter int VALUE_BITS = SLE_VALUE_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  sle_req_t request,
	output logic     done,
	output sle_rsp_t result
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	sle_state_t            state_q, state_d;
	sle_cmd_t              cmd_q;
	logic [VALUE_BITS-1:0] key_q;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [CNT_W-1:0]      pos_q, pos_d;
	sle_status_t           status_q, status_d;
	sle_rsp_t              result_q, result_d;
	logic                  done_q;
	sle_cell_ctl_t         ctl;

	logic [VALUE_BITS-1:0] cell_value [CAPACITY];
	logic [CAPACITY-1:0]   lt_vec, le_vec, eq_vec;
	logic [CAPACITY-1:0]   boundary;
	logic [CNT_W-1:0]      lower_pos;
	logic                  accept;
	logic                  full, empty, found;
	logic                  order_bad;

	assign accept = start && !busy;
	assign busy   = state_q != FSM_IDLE;

	// Cell row
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic                  left_le;
		logic [VALUE_BITS-1:0] left_value;
		logic [VALUE_BITS-1:0] right_value;

		if (g == 0) begin : g_head
			assign left_le    = 1'b1;
			assign left_value = key_q;
		end else begin : g_body
			assign left_le    = le_vec[g-1];
			assign left_value = cell_value[g-1];
		end

		if (g == CAPACITY - 1) begin : g_tail
			assign right_value = cell_value[g];
		end else begin : g_inner
			assign right_value = cell_value[g+1];
		end

		sle_cell #(
			.INDEX      (g),
			.CNT_W      (CNT_W),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.count       (count_q),
			.key         (key_q),
			.left_le     (left_le),
			.left_value  (left_value),
			.right_value (right_value),
			.value       (cell_value[g]),
			.lt          (lt_vec[g]),
			.le          (le_vec[g]),
			.eq          (eq_vec[g])
		);
	end

	// Lower bound: the lt flags form a thermometer, find its edge
	assign boundary = ~lt_vec & {lt_vec[CAPACITY-2:0], 1'b1};
	always_comb begin
		lower_pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (boundary[i])
				lower_pos = lower_pos | CNT_W'(i);
		end
		if (lt_vec[CAPACITY-1])
			lower_pos = CNT_W'(CAPACITY);
	end

	assign full  = count_q == CNT_W'(CAPACITY);
	assign empty = count_q == '0;
	assign found = |eq_vec;

	// Sequencer: next state, cell control, count, position, status
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		count_d  = count_q;
		pos_d    = pos_q;
		status_d = status_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept)
					state_d = FSM_CMP;
			end
			FSM_CMP: begin
				ctl.cmp = 1'b1;
				state_d = FSM_APPLY;
			end
			FSM_APPLY: begin
				state_d  = FSM_REPORT;
				pos_d    = '0;
				status_d = ST_OK;
				unique case (cmd_q)
					CMD_PUSH: begin
						pos_d = lower_pos;
						if (full) begin
							status_d = ST_FULL;
						end else begin
							ctl.ins = 1'b1;
							count_d = count_q + 1'b1;
						end
					end
					CMD_POP_MIN: begin
						if (empty) begin
							status_d = ST_EMPTY;
						end else begin
							ctl.del_min = 1'b1;
							count_d     = count_q - 1'b1;
						end
					end
					CMD_POP_MAX: begin
						if (empty)
							status_d = ST_EMPTY;
						else
							count_d = count_q - 1'b1;
					end
					CMD_REMOVE: begin
						pos_d = lower_pos;
						if (found) begin
							ctl.del_at = 1'b1;
							count_d    = count_q - 1'b1;
						end else begin
							status_d = ST_NOT_FOUND;
						end
					end
					CMD_SEARCH: pos_d = lower_pos;
					default: ;
				endcase
			end
			FSM_REPORT: state_d = FSM_IDLE;
			default: state_d = FSM_IDLE;
		endcase
	end

	// Gather min, max and median taps from the cell row
	always_comb begin
		logic [VALUE_BITS-1:0] max_sel;
		logic [VALUE_BITS-1:0] med_sel;
		max_sel = '0;
		med_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CNT_W'(i + 1) == count_q)
				max_sel = max_sel | cell_value[i];
			if (!empty && CNT_W'(i) == (count_q >> 1))
				med_sel = med_sel | cell_value[i];
		end
		result_d.min_value    = empty ? '0 : DATA_W'(cell_value[0]);
		result_d.max_value    = DATA_W'(max_sel);
		result_d.median_value = DATA_W'(med_sel);
		result_d.entry_count  = COUNT_W'(count_q);
		result_d.position     = COUNT_W'(pos_q);
		result_d.status       = status_q;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= state_q == FSM_REPORT;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= sle_cmd_t'(request.command);
			key_q <= VALUE_BITS'(request.value);
		end
		pos_q    <= pos_d;
		status_q <= status_d;
		if (state_q == FSM_REPORT)
			result_q <= result_d;
	end

	assign done   = done_q;
	assign result = result_q;

	// Order check over occupied cells, used by the assertions only
	always_comb begin
		order_bad = 1'b0;
		for (int i = 1; i < CAPACITY; i++) begin
			if (CNT_W'(i) < count_q && cell_value[i-1] > cell_value[i])
				order_bad = 1'b1;
		end
	end

	`SLE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`SLE_ASSERT_NEXT(a_accept_cmp, accept, state_q == FSM_CMP, "accepted beat did not start compare")
	`SLE_ASSERT_NOW(a_done_idle, done_q, state_q == FSM_IDLE && !$past(done_q), "done not a single beat")
	`SLE_ASSERT_NEXT(a_full_hold, state_q == FSM_APPLY && cmd_q == CMD_PUSH && full, $stable(count_q), "push into full list changed count")
	`SLE_ASSERT_NOW(a_sorted, state_q == FSM_REPORT, !order_bad, "cell row out of order")

endmodule

/* tb/sv/sle_list_checker.sv */
// Watches the command and result channels of the sorted list engine, keeps a
// shadow copy of the list, and compares every result beat with its prediction.
module sle_list_checker import sle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  sle_req_t request,
	input  logic     done,
	input  sle_rsp_t result,
	output int       errors,
	output int       pending,
	output int       beats_checked,
	output int       full_hits,
	output int       empty_hits,
	output int       miss_hits
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = SLE_CAPACITY;

	// Shadow of the stored list, ascending
	logic [DATA_W-1:0] shadow [CAP];
	int                shadow_count = 0;
	sle_rsp_t          expected_results[$];
	sle_rsp_t          want;

	// First index whose entry is not less than key
	function automatic int first_not_less(logic [DATA_W-1:0] key);
		int i;
		i = 0;
		while (i < shadow_count && shadow[i] < key)
			i++;
		return i;
	endfunction

	// Applies one command to the shadow list and returns the result it implies
	function automatic sle_rsp_t apply_to_shadow(sle_req_t rq);
		sle_rsp_t    r;
		int          pos;
		int          at;
		int          i;
		sle_status_t st;
		pos = 0;
		st  = ST_OK;
		case (rq.command)
			CMD_PUSH: begin
				pos = first_not_less(rq.value);
				if (shadow_count >= CAP) begin
					st = ST_FULL;
				end else begin
					// duplicates land after the equal entries
					at = 0;
					while (at < shadow_count && shadow[at] <= rq.value)
						at++;
					for (i = shadow_count; i > at; i--)
						shadow[i] = shadow[i-1];
					shadow[at] = rq.value;
					shadow_count++;
				end
			end
			CMD_POP_MIN: begin
				if (shadow_count == 0) begin
					st = ST_EMPTY;
				end else begin
					for (i = 0; i + 1 < shadow_count; i++)
						shadow[i] = shadow[i+1];
					shadow_count--;
				end
			end
			CMD_POP_MAX: begin
				if (shadow_count == 0)
					st = ST_EMPTY;
				else
					shadow_count--;
			end
			CMD_REMOVE: begin
				pos = first_not_less(rq.value);
				if (pos < shadow_count && shadow[pos] == rq.value) begin
					for (i = pos; i + 1 < shadow_count; i++)
						shadow[i] = shadow[i+1];
					shadow_count--;
				end else begin
					st = ST_NOT_FOUND;
				end
			end
			CMD_SEARCH: pos = first_not_less(rq.value);
			default: ;
		endcase
		if (shadow_count == 0) begin
			r.min_value    = '0;
			r.max_value    = '0;
			r.median_value = '0;
		end else begin
			r.min_value    = shadow[0];
			r.max_value    = shadow[shadow_count-1];
			r.median_value = shadow[shadow_count/2];
		end
		r.entry_count = COUNT_W'(shadow_count);
		r.position    = COUNT_W'(pos);
		r.status      = st;
		return r;
	endfunction

	task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] got_v);
		if (got_v !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, got_v);
		end
	endtask

	// Compare the result beat first, then record the command taken at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_count = 0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected, got %h", $time, result);
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					check_field("min_value", want.min_value, result.min_value);
					check_field("max_value", want.max_value, result.max_value);
					check_field("median_value", want.median_value, result.median_value);
					check_field("entry_count", DATA_W'(want.entry_count),
						DATA_W'(result.entry_count));
					check_field("position", DATA_W'(want.position), DATA_W'(result.position));
					check_field("status", DATA_W'(want.status), DATA_W'(result.status));
					beats_checked++;
					case (want.status)
						ST_FULL:      full_hits++;
						ST_EMPTY:     empty_hits++;
						ST_NOT_FOUND: miss_hits++;
						default: ;
					endcase
				end
			end
			if (start && !busy)
				expected_results.insert(expected_results.size(), apply_to_shadow(request));
			pending = expected_results.size();
		end
	end

endmodule

/* tb/sv/tb_sorted_list_engine.sv */
module tb_sorted_list_engine import sle_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1930;
	localparam int LIMIT_CYCLES = 200000;

	// Command codes the engine ignores
	localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD_C = 3'd7;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	sle_req_t request;
	logic     done;
	sle_rsp_t result;

	int errors;
	int pending;
	int beats_checked;
	int full_hits;
	int empty_hits;
	int miss_hits;
	int issued = 0;

	sorted_list_engine dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	sle_list_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.request       (request),
		.done          (done),
		.result        (result),
		.errors        (errors),
		.pending       (pending),
		.beats_checked (beats_checked),
		.full_hits     (full_hits),
		.empty_hits    (empty_hits),
		.miss_hits     (miss_hits)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop if the engine hangs
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("timeout after %0d cycles", LIMIT_CYCLES);
		$display("CHECKS FAILED");
		$finish;
	end

	// Drive one command beat from a falling edge; return at the falling edge after it is taken
	task automatic send_beat(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val, bit may_idle);
		if (may_idle)
			while ($urandom_range(99) < 17) begin
				start <= 1'b0;
				@(negedge clk);
			end
		start   <= 1'b1;
		request <= '{command: cmd, value: val};
		do
			@(posedge clk);
		while (busy);
		issued++;
		@(negedge clk);
	endtask

	// Small values repeat often, so removes and duplicate pushes hit
	function automatic logic [DATA_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 45)
			return DATA_W'($urandom_range(15));
		if (roll < 55)
			case ($urandom_range(2))
				0: return '0;
				1: return '1;
				default: return {1'b1, {(DATA_W-1){1'b0}}};
			endcase
		return $urandom;
	endfunction

	// Phase 0 fills the list toward full, phase 1 drains it, phase 2 mixes
	function automatic logic [CMD_W-1:0] pick_command(int phase);
		int roll;
		int w_push;
		int w_min;
		int w_max;
		int w_rem;
		roll = $urandom_range(99);
		case (phase)
			0: begin
				w_push = 60; w_min = 8; w_max = 8; w_rem = 10;
			end
			1: begin
				w_push = 15; w_min = 25; w_max = 25; w_rem = 20;
			end
			default: begin
				w_push = 30; w_min = 12; w_max = 12; w_rem = 20;
			end
		endcase
		if (roll < w_push)
			return CMD_PUSH;
		if (roll < w_push + w_min)
			return CMD_POP_MIN;
		if (roll < w_push + w_min + w_max)
			return CMD_POP_MAX;
		if (roll < w_push + w_min + w_max + w_rem)
			return CMD_REMOVE;
		if (roll < 96)
			return CMD_SEARCH;
		case ($urandom_range(2))
			0: return CMD_RSVD_A;
			1: return CMD_RSVD_B;
			default: return CMD_RSVD_C;
		endcase
	endfunction

	initial begin
		int k;
		int phase;
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty list, ignored codes, extremes, duplicates, misses
		send_beat(CMD_POP_MIN, '0, 1'b1);
		send_beat(CMD_POP_MAX, '0, 1'b1);
		send_beat(CMD_REMOVE, 32'd5, 1'b1);
		send_beat(CMD_SEARCH, '1, 1'b1);
		send_beat(CMD_RSVD_A, 32'h1234_5678, 1'b1);
		send_beat(CMD_RSVD_B, '1, 1'b1);
		send_beat(CMD_RSVD_C, '0, 1'b1);
		send_beat(CMD_PUSH, '1, 1'b1);
		send_beat(CMD_PUSH, '0, 1'b1);
		send_beat(CMD_PUSH, 32'd7, 1'b1);
		send_beat(CMD_PUSH, 32'd7, 1'b1);
		send_beat(CMD_PUSH, 32'h8000_0000, 1'b1);
		send_beat(CMD_SEARCH, 32'd7, 1'b1);
		send_beat(CMD_SEARCH, '1, 1'b1);
		send_beat(CMD_SEARCH, 32'd8, 1'b1);
		send_beat(CMD_REMOVE, 32'd8, 1'b1);
		send_beat(CMD_REMOVE, 32'd7, 1'b1);
		send_beat(CMD_REMOVE, '1, 1'b1);
		send_beat(CMD_POP_MAX, '0, 1'b1);
		send_beat(CMD_POP_MIN, '0, 1'b1);
		send_beat(CMD_POP_MIN, '0, 1'b1);
		send_beat(CMD_POP_MIN, '0, 1'b1);

		// Random: fill, drain and mixed phases; a long back-to-back stretch in the middle
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			phase = (k / 45) % 3;
			send_beat(pick_command(phase), pick_value(), !(k >= 700 && k < 1000));
		end
		start <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Issued %0d commands, checked %0d results", issued, beats_checked);
		$display("Pushes refused as full: %0d, pops on empty: %0d, removes of absent: %0d",
			full_hits, empty_hits, miss_hits);
		if (errors == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, pending);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/sle_pkg.sv
rtl/sle_cell.sv
rtl/sorted_list_engine.sv
tb/sv/sle_list_checker.sv
tb/sv/tb_sorted_list_engine.sv
